// File: hdl/assert_macros.svh
// Assertion helpers for the limiter blocks.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define BTBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the next cycle outside reset.
`define BTBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/btbl_pkg.sv
`default_nettype none

package btbl_pkg;

  localparam int unsigned RATE_W         = 32;
  localparam int unsigned TOKEN_W        = 42;
  localparam int unsigned COUNT_W        = 33;
  localparam int unsigned MS_W           = 10;
  localparam int unsigned MILLI_W        = 10;
  localparam int unsigned MS_PER_SECOND  = 1000;
  localparam int unsigned MILLI_PER_BYTE = 1000;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_TICK    = 1'b1
  } kind_e;

  // Classification of one item, passed from front to back.
  typedef struct packed {
    kind_e kind;
    logic  zero_bytes;
  } flags_t;

endpackage

`default_nettype wire

// File: hdl/btbl_front.sv
`default_nettype none

module btbl_front import btbl_pkg::*; #(
  parameter int unsigned REQUEST_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_valid_i,
  output logic                                   s_ready_o,
  input  wire kind_e                             s_kind_i,
  input  wire logic [REQUEST_BITS-1:0]           s_bytes_i,
  output logic                                   q_valid_o,
  input  wire logic                              q_ready_i,
  output flags_t                                 q_flags_o,
  output logic [REQUEST_BITS-1:0]                q_bytes_o,
  output logic [REQUEST_BITS+MILLI_W-1:0]        q_need_o
);

  localparam int unsigned NEED_W = REQUEST_BITS + MILLI_W;

  logic                    valid_d, valid_q;
  flags_t                  flags_d, flags_q;
  logic [REQUEST_BITS-1:0] bytes_d, bytes_q;
  logic [NEED_W-1:0]       need_d, need_q;
  logic                    take;

  assign s_ready_o = !valid_q || q_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    flags_d = flags_q;
    bytes_d = bytes_q;
    need_d  = need_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
    if (take) begin
      flags_d.kind       = s_kind_i;
      flags_d.zero_bytes = (s_bytes_i == '0);
      bytes_d            = s_bytes_i;
      // milli-bytes this request would draw from the bucket
      need_d             = NEED_W'(s_bytes_i) * NEED_W'(MILLI_PER_BYTE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    bytes_q <= bytes_d;
    need_q  <= need_d;
  end

  assign q_valid_o = valid_q;
  assign q_flags_o = flags_q;
  assign q_bytes_o = bytes_q;
  assign q_need_o  = need_q;

endmodule

`default_nettype wire

// File: hdl/btbl_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module btbl_fifo import btbl_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [WIDTH-1:0]      rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `BTBL_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// File: hdl/btbl_back.sv
`default_nettype none

`include "assert_macros.svh"

module btbl_back import btbl_pkg::*; #(
  parameter int unsigned REQUEST_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [RATE_W-1:0]                 cfg_wdata_i,
  input  wire logic                              q_valid_i,
  output logic                                   q_ready_o,
  input  wire flags_t                            q_flags_i,
  input  wire logic [REQUEST_BITS-1:0]           q_bytes_i,
  input  wire logic [REQUEST_BITS+MILLI_W-1:0]   q_need_i,
  output logic                                   m_valid_o,
  input  wire logic                              m_ready_i,
  output logic                                   m_accepted_o,
  output logic [COUNT_W-1:0]                     m_recent_o
);

  logic [RATE_W-1:0]  rate_d, rate_q;
  logic [TOKEN_W-1:0] cap_d, cap_q;
  logic [TOKEN_W-1:0] token_d, token_q;
  logic [MS_W-1:0]    ms_d, ms_q;
  logic [COUNT_W-1:0] this_d, this_q;
  logic [COUNT_W-1:0] last_d, last_q;
  logic               out_valid_d, out_valid_q;
  logic               accepted_d, accepted_q;
  logic [COUNT_W-1:0] recent_d, recent_q;

  logic               pop, is_tick, unlimited, enough, grant, deduct, second_end;
  logic [TOKEN_W:0]   tok_sum;
  logic [TOKEN_W-1:0] tick_tok, need_ext;
  logic [COUNT_W:0]   cnt_sum;
  logic [COUNT_W-1:0] cnt_add;

  assign q_ready_o  = !out_valid_q || m_ready_i;
  assign pop        = q_valid_i && q_ready_o;
  assign is_tick    = (q_flags_i.kind == KIND_TICK);
  assign unlimited  = (rate_q == '0);
  assign need_ext   = TOKEN_W'(q_need_i);
  assign enough     = (token_q >= need_ext);
  assign grant      = is_tick || q_flags_i.zero_bytes || unlimited || enough;
  assign deduct     = !is_tick && !q_flags_i.zero_bytes && !unlimited && enough;
  assign second_end = (ms_q >= MS_W'(MS_PER_SECOND - 1));

  // refill, capped at the bucket size
  assign tok_sum  = {1'b0, token_q} + (TOKEN_W + 1)'(rate_q);
  assign tick_tok = (tok_sum > {1'b0, cap_q}) ? cap_q : tok_sum[TOKEN_W-1:0];

  // saturate the current-second counter
  assign cnt_sum = {1'b0, this_q} + (COUNT_W + 1)'(q_bytes_i);
  assign cnt_add = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];

  always_comb begin
    rate_d      = rate_q;
    cap_d       = cap_q;
    token_d     = token_q;
    ms_d        = ms_q;
    this_d      = this_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    accepted_d  = accepted_q;
    recent_d    = recent_q;

    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      if (is_tick) begin
        if (second_end) begin
          last_d = this_q;
          this_d = '0;
          ms_d   = '0;
        end else begin
          ms_d = ms_q + 1'b1;
        end
        if (!unlimited) begin
          token_d = tick_tok;
        end
      end else if (deduct) begin
        token_d = token_q - need_ext;
        this_d  = cnt_add;
      end
      out_valid_d = 1'b1;
      accepted_d  = grant;
      recent_d    = (this_d > last_d) ? this_d : last_d;
    end

    // rate write refills the bucket
    if (cfg_we_i) begin
      rate_d  = cfg_wdata_i;
      cap_d   = TOKEN_W'(cfg_wdata_i) * TOKEN_W'(MILLI_PER_BYTE);
      token_d = cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= '0;
      cap_q       <= '0;
      token_q     <= '0;
      ms_q        <= '0;
      this_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rate_q      <= rate_d;
      cap_q       <= cap_d;
      token_q     <= token_d;
      ms_q        <= ms_d;
      this_q      <= this_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_q <= accepted_d;
    recent_q   <= recent_d;
  end

  assign m_valid_o    = out_valid_q;
  assign m_accepted_o = accepted_q;
  assign m_recent_o   = recent_q;

  `BTBL_ASSERT(a_token_within_cap, token_q <= cap_q, "token store above bucket size")
  `BTBL_ASSERT_NEXT(a_tick_granted, pop && is_tick, m_valid_o && m_accepted_o,
                    "tick reported as refused")
  `BTBL_ASSERT_NEXT(a_unlimited_granted, pop && unlimited, m_valid_o && m_accepted_o,
                    "request refused at unlimited rate")

endmodule

`default_nettype wire

// File: hdl/byte_token_bucket_limiter_unit.sv
// A request is registered in the front stage, the queue and the back stage
// before its result is valid. Throughput: one request per cycle unless the
// output stalls; the back-stage token and counter update is an add, compare
// and select per request. A 2-entry queue lets the front keep accepting while
// the output stalls. Reset (rst_ni low, asynchronous): rate 0 (unlimited),
// empty bucket, meters cleared, all pipeline stages empty.
`default_nettype none

module byte_token_bucket_limiter_unit import btbl_pkg::*; #(
  parameter int unsigned REQUEST_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [RATE_W-1:0]                     cfg_wdata_i,  // bytes_per_second
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  wire logic [((REQUEST_BITS+7)/8)*8-1:0]     s_axis_tdata_i,  // byte_count
  input  wire logic                                  s_axis_tuser_i,  // kind
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  output logic [((COUNT_W+7)/8)*8-1:0]               m_axis_tdata_o,  // recent_bytes
  output logic                                       m_axis_tuser_o   // accepted
);

  localparam int unsigned NEED_W    = REQUEST_BITS + MILLI_W;
  localparam int unsigned ENTRY_W   = $bits(flags_t) + REQUEST_BITS + NEED_W;
  localparam int unsigned M_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  logic                    fq_valid, fq_ready;
  flags_t                  fq_flags;
  logic [REQUEST_BITS-1:0] fq_bytes;
  logic [NEED_W-1:0]       fq_need;
  logic [ENTRY_W-1:0]      wr_entry, rd_entry;
  logic                    qb_valid, qb_ready;
  flags_t                  qb_flags;
  logic [REQUEST_BITS-1:0] qb_bytes;
  logic [NEED_W-1:0]       qb_need;
  logic [COUNT_W-1:0]      recent;

  btbl_front #(
    .REQUEST_BITS(REQUEST_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_kind_i  (kind_e'(s_axis_tuser_i)),
    .s_bytes_i (s_axis_tdata_i[REQUEST_BITS-1:0]),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_flags_o (fq_flags),
    .q_bytes_o (fq_bytes),
    .q_need_o  (fq_need)
  );

  assign wr_entry = {fq_flags, fq_bytes, fq_need};

  btbl_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (wr_entry),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (rd_entry)
  );

  assign qb_flags = flags_t'(rd_entry[ENTRY_W-1 -: $bits(flags_t)]);
  assign qb_bytes = rd_entry[NEED_W +: REQUEST_BITS];
  assign qb_need  = rd_entry[NEED_W-1:0];

  btbl_back #(
    .REQUEST_BITS(REQUEST_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (qb_valid),
    .q_ready_o    (qb_ready),
    .q_flags_i    (qb_flags),
    .q_bytes_i    (qb_bytes),
    .q_need_i     (qb_need),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_accepted_o (m_axis_tuser_o),
    .m_recent_o   (recent)
  );

  assign m_axis_tdata_o = M_TDATA_W'(recent);

endmodule

`default_nettype wire
